@@ rtl/core/mbi2c_pkg.sv @@
// Shared types and constants for the multi-bus I2C master.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mbi2c_pkg;

    localparam int BUS_COUNT       = 4;
    localparam int BUS_W           = 2;
    localparam int LINE_W          = 4;
    localparam int BYTE_W          = 8;
    localparam int BITCNT_W        = 4;
    localparam int BITS_PER_BYTE   = 8;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

    typedef enum logic [2:0] {
        FN_TICK  = 3'd0,
        FN_START = 3'd1,
        FN_STOP  = 3'd2,
        FN_SEND  = 3'd3,
        FN_WACK  = 3'd4,
        FN_READ  = 3'd5,
        FN_ACK   = 3'd6,
        FN_NACK  = 3'd7
    } func_t;

    typedef enum logic [13:0] {
        PH_IDLE = 14'b00000000000001,
        PH_ST1  = 14'b00000000000010,
        PH_ST2  = 14'b00000000000100,
        PH_SP1  = 14'b00000000001000,
        PH_SP2  = 14'b00000000010000,
        PH_WA1  = 14'b00000000100000,
        PH_WA2  = 14'b00000001000000,
        PH_WAP  = 14'b00000010000000,
        PH_SBH  = 14'b00000100000000,
        PH_SBL  = 14'b00001000000000,
        PH_RDL  = 14'b00010000000000,
        PH_RDH  = 14'b00100000000000,
        PH_AK1  = 14'b01000000000000,
        PH_AK2  = 14'b10000000000000
    } phase_t;

    typedef struct packed {
        func_t               func;
        logic [BUS_W-1:0]    bus;
        logic [BYTE_W-1:0]   tx_byte;
        logic                send_ack;
        logic [LINE_W-1:0]   sda_in;
    } cmd_t;

    typedef struct packed {
        logic [LINE_W-1:0]   scl_lines;
        logic [LINE_W-1:0]   sda_lines;
        logic [LINE_W-1:0]   sda_drive;
        logic                busy_res;
        logic                done_res;
        logic [BYTE_W-1:0]   rx_byte;
        logic                ack_failed;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/core/mbi2c_seq.sv @@
// Bit-level sequencer: bus line state, shift register and phase machine.
// Depends on mbi2c_pkg. Advances one half-bit per processed item.
`timescale 1ns / 1ps
`default_nettype none

module mbi2c_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire mbi2c_pkg::cmd_t     item,
    input  wire logic [7:0]          ack_timeout,
    output mbi2c_pkg::res_t          result
);

    mbi2c_pkg::phase_t                       phase_reg, phase_next;
    logic [mbi2c_pkg::BUS_W-1:0]             bus_reg, bus_next;
    logic [mbi2c_pkg::BYTE_W-1:0]            shift_reg, shift_next;
    logic [mbi2c_pkg::BITCNT_W-1:0]          bitcnt_reg, bitcnt_next;
    logic [7:0]                              wait_reg, wait_next;
    logic                                    ackc_reg, ackc_next;
    logic [mbi2c_pkg::LINE_W-1:0]            scl_reg, scl_next;
    logic [mbi2c_pkg::LINE_W-1:0]            sda_reg, sda_next;
    logic [mbi2c_pkg::LINE_W-1:0]            drv_reg, drv_next;
    logic [mbi2c_pkg::BYTE_W-1:0]            rx_reg, rx_next;
    logic                                    fail_reg, fail_next;
    logic                                    done;
    logic                                    s_bit;
    logic [mbi2c_pkg::BITCNT_W-1:0]          bitcnt_inc;
    logic [8:0]                              wait_inc;
    logic [mbi2c_pkg::LINE_W-1:0]            sel;

    // Bit of the addressed bus in the line vectors.
    always_comb
    begin
        sel = '0;
        if (phase_reg == mbi2c_pkg::PH_IDLE)
            sel[item.bus] = 1'b1;
        else
            sel[bus_reg] = 1'b1;
    end

    assign s_bit      = item.sda_in[bus_reg];
    assign bitcnt_inc = bitcnt_reg + 1'b1;
    assign wait_inc   = {1'b0, wait_reg} + 9'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        bus_next    = bus_reg;
        shift_next  = shift_reg;
        bitcnt_next = bitcnt_reg;
        wait_next   = wait_reg;
        ackc_next   = ackc_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        drv_next    = drv_reg;
        rx_next     = rx_reg;
        fail_next   = fail_reg;
        done        = 1'b0;

        if (phase_reg == mbi2c_pkg::PH_IDLE)
        begin
            if (item.func != mbi2c_pkg::FN_TICK
                && {1'b0, item.bus} < (mbi2c_pkg::BUS_W + 1)'(mbi2c_pkg::BUS_COUNT))
            begin
                bus_next  = item.bus;
                fail_next = 1'b0;
                unique case (item.func)
                    mbi2c_pkg::FN_START:
                    begin
                        drv_next   = drv_reg | sel;
                        sda_next   = sda_reg | sel;
                        scl_next   = scl_reg | sel;
                        phase_next = mbi2c_pkg::PH_ST1;
                    end
                    mbi2c_pkg::FN_STOP:
                    begin
                        drv_next   = drv_reg | sel;
                        scl_next   = scl_reg & ~sel;
                        sda_next   = sda_reg & ~sel;
                        phase_next = mbi2c_pkg::PH_SP1;
                    end
                    mbi2c_pkg::FN_SEND:
                    begin
                        shift_next  = item.tx_byte;
                        bitcnt_next = '0;
                        drv_next    = drv_reg | sel;
                        sda_next    = item.tx_byte[7] ? (sda_reg | sel) : (sda_reg & ~sel);
                        scl_next    = scl_reg | sel;
                        phase_next  = mbi2c_pkg::PH_SBH;
                    end
                    mbi2c_pkg::FN_WACK:
                    begin
                        drv_next   = drv_reg & ~sel;
                        sda_next   = sda_reg | sel;
                        wait_next  = '0;
                        phase_next = mbi2c_pkg::PH_WA1;
                    end
                    mbi2c_pkg::FN_READ:
                    begin
                        ackc_next   = item.send_ack;
                        shift_next  = '0;
                        bitcnt_next = '0;
                        drv_next    = drv_reg & ~sel;
                        scl_next    = scl_reg & ~sel;
                        phase_next  = mbi2c_pkg::PH_RDL;
                    end
                    mbi2c_pkg::FN_ACK:
                    begin
                        ackc_next  = 1'b1;
                        scl_next   = scl_reg & ~sel;
                        drv_next   = drv_reg | sel;
                        sda_next   = sda_reg & ~sel;
                        phase_next = mbi2c_pkg::PH_AK1;
                    end
                    mbi2c_pkg::FN_NACK:
                    begin
                        ackc_next  = 1'b0;
                        scl_next   = scl_reg & ~sel;
                        drv_next   = drv_reg | sel;
                        sda_next   = sda_reg | sel;
                        phase_next = mbi2c_pkg::PH_AK1;
                    end
                    default:
                    begin
                        phase_next = mbi2c_pkg::PH_IDLE;
                    end
                endcase
            end
        end
        else if (item.func == mbi2c_pkg::FN_TICK)
        begin
            unique case (phase_reg)
                mbi2c_pkg::PH_ST1:
                begin
                    sda_next   = sda_reg & ~sel;
                    phase_next = mbi2c_pkg::PH_ST2;
                end
                mbi2c_pkg::PH_ST2:
                begin
                    scl_next   = scl_reg & ~sel;
                    phase_next = mbi2c_pkg::PH_IDLE;
                    done       = 1'b1;
                end
                mbi2c_pkg::PH_SP1:
                begin
                    scl_next   = scl_reg | sel;
                    sda_next   = sda_reg | sel;
                    phase_next = mbi2c_pkg::PH_SP2;
                end
                mbi2c_pkg::PH_SP2:
                begin
                    phase_next = mbi2c_pkg::PH_IDLE;
                    done       = 1'b1;
                end
                mbi2c_pkg::PH_WA1:
                begin
                    scl_next   = scl_reg | sel;
                    phase_next = mbi2c_pkg::PH_WA2;
                end
                mbi2c_pkg::PH_WA2:
                begin
                    phase_next = mbi2c_pkg::PH_WAP;
                end
                mbi2c_pkg::PH_WAP:
                begin
                    if (!s_bit)
                    begin
                        scl_next   = scl_reg & ~sel;
                        phase_next = mbi2c_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                    else if (wait_inc > {1'b0, ack_timeout})
                    begin
                        // timed out: fall into a stop
                        fail_next  = 1'b1;
                        drv_next   = drv_reg | sel;
                        scl_next   = scl_reg & ~sel;
                        sda_next   = sda_reg & ~sel;
                        phase_next = mbi2c_pkg::PH_SP1;
                    end
                    else
                    begin
                        wait_next = wait_inc[7:0];
                    end
                end
                mbi2c_pkg::PH_SBH:
                begin
                    scl_next   = scl_reg & ~sel;
                    phase_next = mbi2c_pkg::PH_SBL;
                end
                mbi2c_pkg::PH_SBL:
                begin
                    bitcnt_next = bitcnt_inc;
                    if (bitcnt_inc >= mbi2c_pkg::BITCNT_W'(mbi2c_pkg::BITS_PER_BYTE))
                    begin
                        phase_next = mbi2c_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                    else
                    begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        sda_next   = shift_reg[6] ? (sda_reg | sel) : (sda_reg & ~sel);
                        scl_next   = scl_reg | sel;
                        phase_next = mbi2c_pkg::PH_SBH;
                    end
                end
                mbi2c_pkg::PH_RDL:
                begin
                    scl_next   = scl_reg | sel;
                    shift_next = {shift_reg[6:0], s_bit};
                    phase_next = mbi2c_pkg::PH_RDH;
                end
                mbi2c_pkg::PH_RDH:
                begin
                    bitcnt_next = bitcnt_inc;
                    if (bitcnt_inc >= mbi2c_pkg::BITCNT_W'(mbi2c_pkg::BITS_PER_BYTE))
                    begin
                        // byte complete: hold it and clock out the ack bit
                        rx_next    = shift_reg;
                        scl_next   = scl_reg & ~sel;
                        drv_next   = drv_reg | sel;
                        sda_next   = ackc_reg ? (sda_reg & ~sel) : (sda_reg | sel);
                        phase_next = mbi2c_pkg::PH_AK1;
                    end
                    else
                    begin
                        scl_next   = scl_reg & ~sel;
                        phase_next = mbi2c_pkg::PH_RDL;
                    end
                end
                mbi2c_pkg::PH_AK1:
                begin
                    scl_next   = scl_reg | sel;
                    phase_next = mbi2c_pkg::PH_AK2;
                end
                mbi2c_pkg::PH_AK2:
                begin
                    scl_next   = scl_reg & ~sel;
                    phase_next = mbi2c_pkg::PH_IDLE;
                    done       = 1'b1;
                end
                default:
                begin
                    phase_next = mbi2c_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= mbi2c_pkg::PH_IDLE;
            bus_reg    <= '0;
            shift_reg  <= '0;
            bitcnt_reg <= '0;
            wait_reg   <= '0;
            ackc_reg   <= 1'b0;
            scl_reg    <= '1;
            sda_reg    <= '1;
            drv_reg    <= '1;
            rx_reg     <= '0;
            fail_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            bus_reg    <= bus_next;
            shift_reg  <= shift_next;
            bitcnt_reg <= bitcnt_next;
            wait_reg   <= wait_next;
            ackc_reg   <= ackc_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            drv_reg    <= drv_next;
            rx_reg     <= rx_next;
            fail_reg   <= fail_next;
        end
    end

    always_comb
    begin
        result.scl_lines  = scl_next;
        result.sda_lines  = sda_next;
        result.sda_drive  = drv_next;
        result.busy_res   = (phase_next != mbi2c_pkg::PH_IDLE);
        result.done_res   = done;
        result.rx_byte    = rx_next;
        result.ack_failed = fail_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/multi_bus_i2c_master_unit.sv @@
// Top level of the multi-bus I2C master: input register, sequencer, result register.
// Depends on mbi2c_pkg and mbi2c_seq.
`timescale 1ns / 1ps
`default_nettype none

// Bit-level I2C master for four buses. Each item on cmd is a command or a
// tick; every item gives exactly one result item on res, carrying the line
// levels of all buses after that step. Throughput is one item per clock
// while res_stall is low: an item is registered on entry, runs through the
// sequencer's single half-bit step and lands in the result register. The
// result register is the only thing that holds the pipe: while res_stall is
// high and a result waits, one more item is held in the input register and
// cmd_stall rises after it. The user must write ack_timeout through cfg_write/
// cfg_data only while no item is in flight; the block itself does not enforce this.
module multi_bus_i2c_master_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output      logic                cmd_stall,
    input  wire mbi2c_pkg::cmd_t     cmd,
    output      logic                res_valid,
    input  wire logic                res_stall,
    output      mbi2c_pkg::res_t     res,
    input  wire logic                cfg_write,
    input  wire logic [7:0]          cfg_data
);

    logic                in_valid_reg;
    mbi2c_pkg::cmd_t     in_item_reg;
    logic                out_valid_reg;
    mbi2c_pkg::res_t     out_item_reg;
    logic [7:0]          ack_timeout_reg;
    logic                step;
    mbi2c_pkg::res_t     step_res;

    assign step      = in_valid_reg && (!out_valid_reg || !res_stall);
    assign cmd_stall = in_valid_reg && !step;
    assign res_valid = out_valid_reg;
    assign res       = out_item_reg;

    mbi2c_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (in_item_reg),
        .ack_timeout (ack_timeout_reg),
        .result      (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ack_timeout_reg <= mbi2c_pkg::ACK_TIMEOUT_RST;
        else if (cfg_write)
            ack_timeout_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!cmd_stall)
                in_valid_reg <= cmd_valid;
            if (step)
                out_valid_reg <= 1'b1;
            else if (!res_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
            in_item_reg <= cmd;
        if (step)
            out_item_reg <= step_res;
    end

endmodule

`default_nettype wire

@@ rtl/core/mbi2c_checker.sv @@
// Port-level checks for the multi-bus I2C master, bound to the top level.
// Depends on mbi2c_pkg and multi_bus_i2c_master_unit.
`timescale 1ns / 1ps
`default_nettype none

module mbi2c_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    input  wire logic                cmd_stall,
    input  wire mbi2c_pkg::cmd_t     cmd,
    input  wire logic                res_valid,
    input  wire logic                res_stall,
    input  wire mbi2c_pkg::res_t     res
);

    // a waiting result item holds until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result item changed while stalled");

    // a stalled command item is held by the sender
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
        else $error("command item changed while stalled");

    // a finished command leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.done_res && res.busy_res))
        else $error("done and busy together");

    // with the result side empty nothing backs up into the command side
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !cmd_stall)
        else $error("command stalled with empty result register");

    // the input only stalls behind a waiting, stalled result item
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> res_valid && res_stall)
        else $error("command stalled without result back-pressure");

endmodule

bind multi_bus_i2c_master_unit mbi2c_checker u_mbi2c_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for multi_bus_i2c_master_unit.
// Depends on mbi2c_pkg and the RTL of the block; drives command and tick items,
// predicts every result item in step and checks them field by field.
`timescale 1ns / 1ps

module tb_top;
    import mbi2c_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    cmd_t       cmd = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    res_t       res;
    logic       cfg_write = 1'b0;
    logic [7:0] cfg_data = 8'd0;

    multi_bus_i2c_master_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    // Predicted bus and sequencer state
    phase_t                ph = PH_IDLE;
    logic [BUS_W-1:0]      act_bus = '0;
    logic [BYTE_W-1:0]     shreg = '0;
    logic [BITCNT_W-1:0]   bitcnt = '0;
    logic [7:0]            waitcnt = '0;
    logic                  ack_sel = 1'b0;
    logic [LINE_W-1:0]     scl_q = '1;
    logic [LINE_W-1:0]     sda_q = '1;
    logic [LINE_W-1:0]     drv_q = '1;
    logic [BYTE_W-1:0]     rx_q = '0;
    logic                  fail_q = 1'b0;
    logic [7:0]            tmo = ACK_TIMEOUT_RST;

    cmd_t cmd_backlog[$];
    res_t line_states_due[$];

    int n_queued = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_in_stalls = 0;
    int n_timeouts = 0;
    int n_reads = 0;
    int n_settings = 1;
    int gap_left = 0;
    int burst_left = 0;
    int stall_roll = 0;
    bit hold_done = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void begin_stop_seq();
        drv_q[act_bus] = 1'b1;
        scl_q[act_bus] = 1'b0;
        sda_q[act_bus] = 1'b0;
        ph = PH_SP1;
    endfunction

    function automatic void begin_ack_bit();
        scl_q[act_bus] = 1'b0;
        drv_q[act_bus] = 1'b1;
        sda_q[act_bus] = ~ack_sel;      // ack pulls low
        ph = PH_AK1;
    endfunction

    function automatic void take_command(cmd_t c);
        act_bus = c.bus;
        fail_q = 1'b0;
        case (c.func)
            FN_START:
            begin
                drv_q[act_bus] = 1'b1;
                sda_q[act_bus] = 1'b1;
                scl_q[act_bus] = 1'b1;
                ph = PH_ST1;
            end
            FN_STOP: begin_stop_seq();
            FN_SEND:
            begin
                shreg = c.tx_byte;
                bitcnt = '0;
                drv_q[act_bus] = 1'b1;
                sda_q[act_bus] = shreg[7];
                scl_q[act_bus] = 1'b1;
                ph = PH_SBH;
            end
            FN_WACK:
            begin
                drv_q[act_bus] = 1'b0;
                sda_q[act_bus] = 1'b1;
                waitcnt = '0;
                ph = PH_WA1;
            end
            FN_READ:
            begin
                ack_sel = c.send_ack;
                shreg = '0;
                bitcnt = '0;
                drv_q[act_bus] = 1'b0;
                scl_q[act_bus] = 1'b0;
                ph = PH_RDL;
            end
            FN_ACK:
            begin
                ack_sel = 1'b1;
                begin_ack_bit();
            end
            default:
            begin
                ack_sel = 1'b0;
                begin_ack_bit();
            end
        endcase
    endfunction

    function automatic res_t bus_step(cmd_t c);
        res_t r;
        logic s;
        logic fin;
        logic [8:0] polls;
        fin = 1'b0;
        s = c.sda_in[act_bus];
        if (ph == PH_IDLE) begin
            if (c.func != FN_TICK)
                take_command(c);
        end else if (c.func == FN_TICK) begin
            case (ph)
                PH_ST1:
                begin
                    sda_q[act_bus] = 1'b0;
                    ph = PH_ST2;
                end
                PH_ST2:
                begin
                    scl_q[act_bus] = 1'b0;
                    ph = PH_IDLE;
                    fin = 1'b1;
                end
                PH_SP1:
                begin
                    scl_q[act_bus] = 1'b1;
                    sda_q[act_bus] = 1'b1;
                    ph = PH_SP2;
                end
                PH_SP2:
                begin
                    ph = PH_IDLE;
                    fin = 1'b1;
                end
                PH_WA1:
                begin
                    scl_q[act_bus] = 1'b1;
                    ph = PH_WA2;
                end
                PH_WA2: ph = PH_WAP;
                PH_WAP:
                begin
                    if (!s) begin
                        scl_q[act_bus] = 1'b0;
                        ph = PH_IDLE;
                        fin = 1'b1;
                    end else begin
                        polls = {1'b0, waitcnt} + 9'd1;
                        if (polls > {1'b0, tmo}) begin
                            fail_q = 1'b1;
                            n_timeouts++;
                            begin_stop_seq();
                        end else begin
                            waitcnt = polls[7:0];
                        end
                    end
                end
                PH_SBH:
                begin
                    scl_q[act_bus] = 1'b0;
                    ph = PH_SBL;
                end
                PH_SBL:
                begin
                    bitcnt = bitcnt + 1'b1;
                    if (bitcnt >= BITS_PER_BYTE) begin
                        ph = PH_IDLE;
                        fin = 1'b1;
                    end else begin
                        shreg = shreg << 1;
                        sda_q[act_bus] = shreg[7];
                        scl_q[act_bus] = 1'b1;
                        ph = PH_SBH;
                    end
                end
                PH_RDL:
                begin
                    scl_q[act_bus] = 1'b1;
                    shreg = {shreg[6:0], s};
                    ph = PH_RDH;
                end
                PH_RDH:
                begin
                    bitcnt = bitcnt + 1'b1;
                    if (bitcnt >= BITS_PER_BYTE) begin
                        rx_q = shreg;
                        n_reads++;
                        begin_ack_bit();
                    end else begin
                        scl_q[act_bus] = 1'b0;
                        ph = PH_RDL;
                    end
                end
                PH_AK1:
                begin
                    scl_q[act_bus] = 1'b1;
                    ph = PH_AK2;
                end
                PH_AK2:
                begin
                    scl_q[act_bus] = 1'b0;
                    ph = PH_IDLE;
                    fin = 1'b1;
                end
                default: ph = PH_IDLE;
            endcase
        end
        r.scl_lines  = scl_q;
        r.sda_lines  = sda_q;
        r.sda_drive  = drv_q;
        r.busy_res   = (ph != PH_IDLE);
        r.done_res   = fin;
        r.rx_byte    = rx_q;
        r.ack_failed = fail_q;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    task automatic add_item(func_t f, logic [1:0] b, logic [7:0] tx, logic sa,
                            logic [3:0] sda);
        cmd_t c;
        c.func = f;
        c.bus = b;
        c.tx_byte = tx;
        c.send_ack = sa;
        c.sda_in = sda;
        cmd_backlog.push_back(c);
        n_queued++;
    endtask

    task automatic add_cmd(func_t f, logic [1:0] b);
        add_item(f, b, $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 15));
    endtask

    task automatic add_ticks(int n);
        repeat (n)
            add_cmd(FN_TICK, $urandom_range(0, 3));
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 8'h00;
        if (r < 30)
            return 8'hFF;
        return $urandom_range(0, 255);
    endfunction

    task automatic add_send(logic [1:0] b);
        add_item(FN_SEND, b, pick_byte(), $urandom_range(0, 1), $urandom_range(0, 15));
        add_ticks(2 * BITS_PER_BYTE);
    endtask

    // Polls with SDA high for k ticks, then low; k around the timeout hits both sides
    task automatic add_wait_ack(logic [1:0] b);
        int k;
        int r;
        logic [3:0] sda;
        r = $urandom_range(0, 99);
        if (tmo <= 20 || r >= 97)
            k = (tmo == 0) ? $urandom_range(0, 2) : int'(tmo) - 1 + $urandom_range(0, 2);
        else if (r < 75)
            k = $urandom_range(0, 3);
        else
            k = $urandom_range(4, 10);
        add_cmd(FN_WACK, b);
        add_ticks(2);
        repeat (k)
        begin
            sda = $urandom_range(0, 15);
            sda[b] = 1'b1;
            add_item(FN_TICK, $urandom_range(0, 3), $urandom_range(0, 255),
                     $urandom_range(0, 1), sda);
        end
        sda = $urandom_range(0, 15);
        sda[b] = 1'b0;
        add_item(FN_TICK, $urandom_range(0, 3), $urandom_range(0, 255),
                 $urandom_range(0, 1), sda);
        add_ticks(2);       // finishes the stop after a timeout, else idle ticks
    endtask

    task automatic add_read(logic [1:0] b, logic sa);
        add_item(FN_READ, b, $urandom_range(0, 255), sa, $urandom_range(0, 15));
        add_ticks(2 * BITS_PER_BYTE + 2);
    endtask

    task automatic add_transfer();
        logic [1:0] b;
        int n;
        b = $urandom_range(0, 3);
        n = $urandom_range(1, 3);
        add_cmd(FN_START, b);
        add_ticks(2);
        add_send(b);
        add_wait_ack(b);
        if ($urandom_range(0, 1)) begin
            repeat (n)
            begin
                add_send(b);
                add_wait_ack(b);
            end
        end else begin
            for (int i = 0; i < n; i++)
                add_read(b, (i == n - 1) ? 1'b0 : $urandom_range(0, 1));
        end
        if ($urandom_range(0, 5) == 0) begin
            add_cmd($urandom_range(0, 1) ? FN_ACK : FN_NACK, b);
            add_ticks(2);
        end
        add_cmd(FN_STOP, b);
        add_ticks(2);
    endtask

    task automatic add_noise();
        case ($urandom_range(0, 3))
            0:
            begin
                repeat ($urandom_range(1, 4))
                    add_cmd(func_t'($urandom_range(0, 7)), $urandom_range(0, 3));
            end
            1:
            begin
                // sequence cut short; the next command may land while busy
                add_cmd(func_t'($urandom_range(1, 7)), $urandom_range(0, 3));
                add_ticks($urandom_range(0, 3));
            end
            2:
            begin
                add_cmd(FN_START, $urandom_range(0, 3));
                add_cmd(func_t'($urandom_range(1, 7)), $urandom_range(0, 3));
                add_ticks(2);
            end
            default: add_ticks($urandom_range(1, 3));
        endcase
    endtask

    task automatic add_traffic(int count);
        int stop_at;
        stop_at = n_queued + count;
        while (n_queued < stop_at) begin
            if ($urandom_range(0, 99) < 80)
                add_transfer();
            else
                add_noise();
        end
    endtask

    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || cmd_valid || line_states_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_timeout(logic [7:0] v);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        tmo = v;
        n_settings++;
    endtask

    // ---------------------------------------------------------------- driver

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        case ((n_accepted / 230) % 3)
            0: return 0;
            1: return (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(4, 12);
            default:
            begin
                if (r < 50)
                    return 0;
                if (r < 85)
                    return $urandom_range(1, 3);
                if (r < 97)
                    return $urandom_range(4, 10);
                return $urandom_range(15, 60);
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cmd_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (cmd_valid && !cmd_stall) begin
                line_states_due.push_back(bus_step(cmd));
                n_accepted++;
            end
            if (cmd_valid && cmd_stall)
                n_in_stalls++;
            if (!cmd_valid || !cmd_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    cmd_valid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    cmd <= cmd_backlog.pop_front();
                    cmd_valid <= 1'b1;
                    gap_left = next_gap();
                end else begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        n_errors++;
        if (n_errors <= 40)
            $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
                     $realtime, n_results, what, got, want);
    endtask

    task automatic check_result(res_t got);
        res_t want;
        if (line_states_due.size() == 0) begin
            report_mismatch("unexpected item", 16'(got), 16'h0);
        end else begin
            want = line_states_due.pop_front();
            if (got.scl_lines !== want.scl_lines)
                report_mismatch("scl_lines", got.scl_lines, want.scl_lines);
            if (got.sda_lines !== want.sda_lines)
                report_mismatch("sda_lines", got.sda_lines, want.sda_lines);
            if (got.sda_drive !== want.sda_drive)
                report_mismatch("sda_drive", got.sda_drive, want.sda_drive);
            if (got.busy_res !== want.busy_res)
                report_mismatch("busy_res", got.busy_res, want.busy_res);
            if (got.done_res !== want.done_res)
                report_mismatch("done_res", got.done_res, want.done_res);
            if (got.rx_byte !== want.rx_byte)
                report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
            if (got.ack_failed !== want.ack_failed)
                report_mismatch("ack_failed", got.ack_failed, want.ack_failed);
        end
        n_results++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else begin
            if (res_valid && !res_stall)
                check_result(res);
            stall_roll = $urandom_range(0, 99);
            if (burst_left > 0) begin
                burst_left--;
                res_stall <= 1'b1;
            end else if (!hold_done && cmd_valid && n_results >= 400) begin
                // long hold-off so the pipe fills and the input side stalls
                hold_done = 1'b1;
                burst_left = 120;
                res_stall <= 1'b1;
            end else begin
                case ((n_results / 170) % 3)
                    0: res_stall <= 1'b0;
                    1: res_stall <= (stall_roll < 30);
                    default:
                    begin
                        if (stall_roll < 4)
                            burst_left = $urandom_range(8, 40);
                        res_stall <= (stall_roll < 15);
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle tick, command while busy, ack/nack bits, prompt ack, stop
        add_item(FN_TICK, 2'd0, 8'h00, 1'b0, 4'h0);
        add_item(FN_START, 2'd3, 8'hFF, 1'b1, 4'hF);
        add_item(FN_STOP, 2'd1, 8'h00, 1'b0, 4'h0);
        add_ticks(2);
        add_item(FN_ACK, 2'd1, 8'hA5, 1'b0, 4'hF);
        add_ticks(2);
        add_item(FN_NACK, 2'd2, 8'h5A, 1'b1, 4'h0);
        add_ticks(2);
        add_item(FN_WACK, 2'd0, 8'h00, 1'b0, 4'hF);
        add_ticks(2);
        add_item(FN_TICK, 2'd3, 8'hFF, 1'b1, 4'hE);
        add_item(FN_STOP, 2'd0, 8'hFF, 1'b1, 4'hF);
        add_ticks(2);

        add_traffic(300);
        set_timeout(8'd0);
        add_traffic(200);
        set_timeout(8'd255);
        add_traffic(250);
        set_timeout($urandom_range(1, 8));
        add_traffic(250);
        set_timeout($urandom_range(9, 254));
        add_traffic(200);

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Checked %0d items under %0d ack timeout settings (0 and 255 included).",
                 n_results, n_settings);
        $display("Reads %0d, ack timeouts %0d, cycles with input stalled %0d.",
                 n_reads, n_timeouts, n_in_stalls);
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d results still due", line_states_due.size());
        $display("Verification failed");
        $finish;
    end

endmodule
